FILE: hdl/ihf_pkg.sv
// ihf_pkg: types, constants and helpers for the ipv4 header filter
// no dependencies; imported by the result interface and every module of the block
package ihf_pkg;

  localparam int ADDR_OCTETS = 4;
  localparam int POS_W       = 5;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [POS_W-1:0] POS_VERSION = 5'd0;
  localparam logic [POS_W-1:0] POS_FRAG_HI = 5'd6;
  localparam logic [POS_W-1:0] POS_FRAG_LO = 5'd7;
  localparam logic [POS_W-1:0] POS_PROTO   = 5'd9;
  localparam logic [POS_W-1:0] POS_SRC     = 5'd12;
  localparam logic [POS_W-1:0] POS_DST     = POS_SRC + 5'(ADDR_OCTETS);
  localparam logic [POS_W-1:0] POS_SRC_END = POS_DST - 5'd1;
  localparam logic [POS_W-1:0] POS_LAST    = POS_DST + 5'(ADDR_OCTETS) - 5'd1;

  localparam logic [3:0] IPV4_VERSION = 4'h4;
  localparam logic [7:0] PROTO_TCP    = 8'h06;
  localparam logic [7:0] PROTO_UDP    = 8'h11;

  // register indexes on the configuration port
  localparam logic REG_SOURCE_FILTER = 1'b0;
  localparam logic REG_DEST_FILTER   = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_VERSION   = 3'd1,
    ERR_FRAGMENT  = 3'd2,
    ERR_PROTOCOL  = 3'd3,
    ERR_SRC_MISS  = 3'd4,
    ERR_DST_MISS  = 3'd5
  } ihf_err_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] error_code;
    logic [5:0] header_length;
    logic [7:0] protocol_number;
  } ihf_result_t;

  typedef struct packed {
    logic        valid;
    ihf_result_t res;
  } ihf_push_t;

  // octet k of a filter word, first octet in the top byte
  function automatic logic [7:0] filter_octet(input logic [31:0] filt, input logic [1:0] k);
    logic [1:0] sel;
    sel = 2'(ADDR_OCTETS - 1) - k;
    return filt[8*sel +: 8];
  endfunction

endpackage

FILE: hdl/ihf_if.sv
// ihf_if: valid/ready channel interfaces for header bytes and filter results
// depends on ihf_pkg, which the result interface imports
interface ihf_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       start_of_packet;

  modport source (output valid, header_byte, start_of_packet, input ready);
  modport sink   (input valid, header_byte, start_of_packet, output ready);
endinterface

interface ihf_res_if
  import ihf_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] error_code;
  logic [5:0] header_length;
  logic [7:0] protocol_number;

  modport source (output valid, accepted, error_code, header_length, protocol_number,
                  input ready);
  modport sink   (input valid, accepted, error_code, header_length, protocol_number,
                  output ready);
endinterface

FILE: hdl/ihf_cfg.sv
// ihf_cfg: apb-style register file holding the source and destination filters
// depends on ihf_pkg for register indexes and address width
module ihf_cfg
  import ihf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [31:0]           source_filter,
  output logic [31:0]           dest_filter
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_filter <= '0;
      dest_filter   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SOURCE_FILTER: source_filter <= pwdata;
        REG_DEST_FILTER:   dest_filter   <= pwdata;
        default:           source_filter <= source_filter;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SOURCE_FILTER: prdata = source_filter;
      REG_DEST_FILTER:   prdata = dest_filter;
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hdl/ihf_parse.sv
// ihf_parse: input register, header parse state and per-byte checks
// depends on ihf_pkg for positions, error codes and the result push struct
module ihf_parse
  import ihf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header_byte,
  input  logic        start_of_packet,
  input  logic [31:0] source_filter,
  input  logic [31:0] dest_filter,
  input  logic        room,
  output ihf_push_t   push
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sop;
  logic       advance;

  // parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             parse_done, parse_done_next;
  logic [3:0]       header_words, header_words_next;
  logic [7:0]       protocol_seen, protocol_seen_next;
  logic [4:0]       offset_high_bits, offset_high_bits_next;
  logic             address_mismatch, address_mismatch_next;

  // state as seen by this byte, after a start clears it
  logic [POS_W-1:0] pos;
  logic             done_eff;
  logic             mism_eff;
  logic [7:0]       oct;
  logic             miss;
  logic             emit;
  ihf_result_t      res;

  assign advance  = s1_valid && room;
  assign in_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= header_byte;
      s1_sop  <= start_of_packet;
    end
  end

  always_comb begin
    pos      = s1_sop ? POS_VERSION : byte_position;
    done_eff = s1_sop ? 1'b0 : parse_done;
    mism_eff = s1_sop ? 1'b0 : address_mismatch;

    byte_position_next    = s1_sop ? POS_VERSION : byte_position;
    parse_done_next       = done_eff;
    header_words_next     = s1_sop ? 4'd0 : header_words;
    protocol_seen_next    = s1_sop ? 8'd0 : protocol_seen;
    offset_high_bits_next = s1_sop ? 5'd0 : offset_high_bits;
    address_mismatch_next = mism_eff;

    if (pos >= POS_DST) begin
      oct = filter_octet(dest_filter, 2'(pos - POS_DST));
    end else begin
      oct = filter_octet(source_filter, 2'(pos - POS_SRC));
    end
    miss = (oct != 8'd0) && (oct != s1_byte);

    emit = 1'b0;
    res  = '{accepted: 1'b0, error_code: ERR_NONE, header_length: 6'd0,
             protocol_number: 8'd0};

    if (!done_eff) begin
      byte_position_next = pos + 5'd1;
      if (pos == POS_VERSION) begin
        if (s1_byte[7:4] != IPV4_VERSION) begin
          emit           = 1'b1;
          res.error_code = ERR_VERSION;
        end else begin
          header_words_next = s1_byte[3:0];
        end
      end else if (pos == POS_FRAG_HI) begin
        offset_high_bits_next = s1_byte[4:0];
      end else if (pos == POS_FRAG_LO) begin
        if ((offset_high_bits != 5'd0) || (s1_byte != 8'd0)) begin
          emit           = 1'b1;
          res.error_code = ERR_FRAGMENT;
        end
      end else if (pos == POS_PROTO) begin
        protocol_seen_next = s1_byte;
        if ((s1_byte != PROTO_TCP) && (s1_byte != PROTO_UDP)) begin
          emit                = 1'b1;
          res.error_code      = ERR_PROTOCOL;
          res.protocol_number = s1_byte;
        end
      end else if ((pos >= POS_SRC) && (pos <= POS_LAST)) begin
        address_mismatch_next = mism_eff | miss;
        if (pos == POS_SRC_END) begin
          if (mism_eff | miss) begin
            emit                = 1'b1;
            res.error_code      = ERR_SRC_MISS;
            res.protocol_number = protocol_seen;
          end else begin
            address_mismatch_next = 1'b0;
          end
        end else if (pos == POS_LAST) begin
          emit                = 1'b1;
          res.protocol_number = protocol_seen;
          if (mism_eff | miss) begin
            res.error_code = ERR_DST_MISS;
          end else begin
            res.accepted      = 1'b1;
            res.header_length = {header_words, 2'b00};
          end
        end
      end
      if (emit) begin
        parse_done_next = 1'b1;
      end
    end

    push.valid = advance && emit;
    push.res   = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_VERSION;
      parse_done       <= 1'b1;
      header_words     <= 4'd0;
      protocol_seen    <= 8'd0;
      offset_high_bits <= 5'd0;
      address_mismatch <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      parse_done       <= parse_done_next;
      header_words     <= header_words_next;
      protocol_seen    <= protocol_seen_next;
      offset_high_bits <= offset_high_bits_next;
      address_mismatch <= address_mismatch_next;
    end
  end

endmodule

FILE: hdl/ihf_res_fifo.sv
// ihf_res_fifo: two-entry result queue that decouples the parser from the sink
// depends on ihf_pkg for the result and push structs
module ihf_res_fifo
  import ihf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ihf_push_t   push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output ihf_result_t out_res
);

  ihf_result_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign room      = (count < 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_res   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/ipv4_header_filter_top.sv
// ipv4_header_filter_top: byte-serial ipv4 header checker with address filters
// a result passes the input register and then the result queue before it leaves
// throughput: one header byte per cycle while the result queue has room, set by the single-pass parse stage
// reset: synchronous active-high rst clears filters to zero, empties the queue
// and leaves the parser waiting for a start-of-packet byte
// depends on ihf_pkg, ihf_if, ihf_cfg, ihf_parse and ihf_res_fifo
module ipv4_header_filter_top
  import ihf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ihf_hdr_if.sink               pkt_in,
  ihf_res_if.source             res_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] source_filter;
  logic [31:0] dest_filter;
  logic        room;
  ihf_push_t   push;
  ihf_result_t out_res;

  // filter registers; the user must write them only while the block is idle, the block does not enforce it
  ihf_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .source_filter (source_filter),
    .dest_filter   (dest_filter)
  );

  // input register plus per-byte checks; one transaction in per cycle
  // as long as the result queue has a free slot
  ihf_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (pkt_in.valid),
    .in_ready        (pkt_in.ready),
    .header_byte     (pkt_in.header_byte),
    .start_of_packet (pkt_in.start_of_packet),
    .source_filter   (source_filter),
    .dest_filter     (dest_filter),
    .room            (room),
    .push            (push)
  );

  // two entries so a stalled sink does not stop the byte stream at once
  ihf_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_res   (out_res)
  );

  assign res_out.accepted        = out_res.accepted;
  assign res_out.error_code      = out_res.error_code;
  assign res_out.header_length   = out_res.header_length;
  assign res_out.protocol_number = out_res.protocol_number;

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for ipv4_header_filter_top, byte-serial header in, one verdict out
// depends on ihf_pkg and ihf_if from hdl and on the block's rtl; reads no files
// predicts every verdict from header bytes as they are accepted and checks each result
module tb;
  import ihf_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  // the block answers through its input register and result queue; leave margin before config writes
  localparam int DRAIN_CYCLES = 8;
  // long receiver hold-off used once to back the result queue up into the input
  localparam int HOLD_CYCLES  = 300;
  // cycles with no transaction on either channel before the run is declared hung
  localparam int IDLE_LIMIT   = 4000;
  localparam int HDR_BYTES    = 20;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_ITEMS  = 215;
  localparam int PRESSURE_PKTS = 60;

  typedef struct packed {
    logic [7:0] hb;
    logic       sop;
  } header_beat_t;

  // header flavors the generator can build
  typedef enum int {
    PKT_GOOD,
    PKT_SRC_MISS,
    PKT_DST_MISS,
    PKT_BAD_VERSION,
    PKT_FRAGMENT,
    PKT_BAD_PROTO,
    PKT_CUT
  } pkt_kind_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  ihf_hdr_if hdr_ch ();
  ihf_res_if res_ch ();

  ipv4_header_filter_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (hdr_ch),
    .res_out (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // bytes waiting to be offered, and verdicts waiting to come out
  header_beat_t header_bytes_q[$];
  ihf_result_t  expected_verdicts[$];

  // bench copy of the filter registers, only changed while the block is idle
  logic [31:0] src_filter_cfg = '0;
  logic [31:0] dst_filter_cfg = '0;

  // parser state of the predictor, reset values match the block after reset
  logic [4:0] parse_pos    = '0;
  logic       parse_idle   = 1'b1;
  logic [3:0] ihl_words    = '0;
  logic [7:0] proto_byte   = '0;
  logic [4:0] frag_hi_bits = '0;
  logic       addr_miss    = 1'b0;

  int          fail_count    = 0;
  int          items_queued  = 0;
  int          idle_cycles   = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          burst_len     = 1;
  int          burst_sent    = 0;
  int          gap_left      = 0;
  logic        offer;
  logic        take;
  logic [31:0] rx_cycle      = '0;
  ihf_result_t want;

  // advance the parse by one accepted byte and queue the verdict it causes, if any
  task automatic predict_verdict(input logic [7:0] hb, input logic sop);
    logic [4:0]  pos;
    logic [7:0]  filt_octet;
    ihf_result_t verdict;
    bit          done;
    done    = 1'b0;
    verdict = '0;
    // a start restarts the parse wherever it lands
    if (sop) begin
      parse_pos    = '0;
      parse_idle   = 1'b0;
      ihl_words    = '0;
      proto_byte   = '0;
      frag_hi_bits = '0;
      addr_miss    = 1'b0;
    end
    // after a verdict, or before any start, bytes fall on the floor
    if (!parse_idle) begin
      pos       = parse_pos;
      parse_pos = parse_pos + 5'd1;
      if (pos == POS_VERSION) begin
        if (hb[7:4] != IPV4_VERSION) begin
          verdict.error_code = ERR_VERSION;
          done = 1'b1;
        end else begin
          ihl_words = hb[3:0];
        end
      end else if (pos == POS_FRAG_HI) begin
        // flag bits are dropped, only the offset matters
        frag_hi_bits = hb[4:0];
      end else if (pos == POS_FRAG_LO) begin
        if ({frag_hi_bits, hb} != 13'd0) begin
          verdict.error_code = ERR_FRAGMENT;
          done = 1'b1;
        end
      end else if (pos == POS_PROTO) begin
        proto_byte = hb;
        if (hb != PROTO_TCP && hb != PROTO_UDP) begin
          verdict.error_code      = ERR_PROTOCOL;
          verdict.protocol_number = hb;
          done = 1'b1;
        end
      end else if (pos >= POS_SRC && pos <= POS_LAST) begin
        // a zero filter octet is a wildcard; a miss is only reported at the last octet of its address
        if (pos < POS_DST) begin
          filt_octet = src_filter_cfg[31 - 8*int'(pos - POS_SRC) -: 8];
        end else begin
          filt_octet = dst_filter_cfg[31 - 8*int'(pos - POS_DST) -: 8];
        end
        if (filt_octet != 8'd0 && filt_octet != hb) addr_miss = 1'b1;
        if (pos == POS_SRC_END && addr_miss) begin
          verdict.error_code      = ERR_SRC_MISS;
          verdict.protocol_number = proto_byte;
          done = 1'b1;
        end else if (pos == POS_LAST) begin
          verdict.protocol_number = proto_byte;
          if (addr_miss) begin
            verdict.error_code = ERR_DST_MISS;
          end else begin
            // small ihl is passed through as given
            verdict.accepted      = 1'b1;
            verdict.error_code    = ERR_NONE;
            verdict.header_length = {ihl_words, 2'b00};
          end
          done = 1'b1;
        end
      end
      if (done) begin
        parse_idle = 1'b1;
        expected_verdicts.push_back(verdict);
      end
    end
  endtask

  task automatic queue_beat(input logic [7:0] hb, input logic sop);
    header_bytes_q.push_back({hb, sop});
    items_queued++;
  endtask

  // build one header of the given flavor; addresses follow the current filters
  task automatic queue_header(input pkt_kind_t kind);
    logic [7:0]  hdr [HDR_BYTES];
    logic [12:0] frag_offset;
    logic [3:0]  bad_version;
    logic [7:0]  filt_octet;
    int          hdr_len;
    int          miss_at;
    int          opt_len;
    for (int i = 0; i < HDR_BYTES; i++) hdr[i] = 8'($urandom);
    hdr_len = HDR_BYTES;
    // stray byte between headers: ignored, or part of the parse after a cut header
    if ($urandom_range(0, 9) == 0) queue_beat(8'($urandom), 1'b0);
    // ihl mostly 5 or 6, sometimes anything including values below 5
    hdr[0][3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(5, 6));
    if (kind == PKT_BAD_VERSION) begin
      bad_version = 4'($urandom_range(0, 14));
      if (bad_version >= IPV4_VERSION) bad_version = bad_version + 4'd1;
      hdr[0][7:4] = bad_version;
    end else begin
      hdr[0][7:4] = IPV4_VERSION;
    end
    // flag bits stay random, only the offset is forced
    frag_offset = (kind == PKT_FRAGMENT) ? 13'($urandom_range(1, 8191)) : 13'd0;
    hdr[POS_FRAG_HI][4:0] = frag_offset[12:8];
    hdr[POS_FRAG_LO]      = frag_offset[7:0];
    if (kind == PKT_BAD_PROTO) begin
      while (hdr[POS_PROTO] == PROTO_TCP || hdr[POS_PROTO] == PROTO_UDP) begin
        hdr[POS_PROTO] = 8'($urandom);
      end
    end else begin
      hdr[POS_PROTO] = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
    end
    for (int k = 0; k < ADDR_OCTETS; k++) begin
      filt_octet = src_filter_cfg[31 - 8*k -: 8];
      if (filt_octet != 8'd0) hdr[POS_SRC + k] = filt_octet;
      filt_octet = dst_filter_cfg[31 - 8*k -: 8];
      if (filt_octet != 8'd0) hdr[POS_DST + k] = filt_octet;
    end
    // one flipped octet; lands on a wildcard now and then and so still matches
    if (kind == PKT_SRC_MISS || kind == PKT_DST_MISS) begin
      miss_at = ((kind == PKT_SRC_MISS) ? int'(POS_SRC) : int'(POS_DST))
                + $urandom_range(0, ADDR_OCTETS - 1);
      hdr[miss_at] = hdr[miss_at] ^ 8'($urandom_range(1, 255));
    end
    if (kind == PKT_CUT) hdr_len = $urandom_range(1, HDR_BYTES - 1);
    for (int i = 0; i < hdr_len; i++) queue_beat(hdr[i], i == 0);
    // a few option bytes, which the block ignores
    if (kind == PKT_GOOD && hdr[0][3:0] > 4'd5) begin
      opt_len = $urandom_range(0, 8);
      for (int i = 0; i < opt_len; i++) queue_beat(8'($urandom), 1'b0);
    end
  endtask

  function automatic pkt_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return PKT_GOOD;
    if (roll < 55) return PKT_SRC_MISS;
    if (roll < 65) return PKT_DST_MISS;
    if (roll < 73) return PKT_BAD_VERSION;
    if (roll < 81) return PKT_FRAGMENT;
    if (roll < 89) return PKT_BAD_PROTO;
    return PKT_CUT;
  endfunction

  // random filter; with wildcards each octet is zero half the time
  function automatic logic [31:0] random_filter(input bit wildcards);
    logic [31:0] filt;
    for (int k = 0; k < ADDR_OCTETS; k++) begin
      if (wildcards && $urandom_range(0, 1) == 0) filt[8*k +: 8] = 8'd0;
      else filt[8*k +: 8] = 8'($urandom_range(1, 255));
    end
    return filt;
  endfunction

  // setup cycle, then access cycle; the write lands when pready is seen high
  task automatic write_filter(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_SOURCE_FILTER) src_filter_cfg = value;
    else dst_filter_cfg = value;
  endtask

  // everything offered and answered, then let the pipeline empty
  task automatic wait_idle();
    while (header_bytes_q.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps, with long gap-free runs
  always @(posedge clk) begin
    if (rst) begin
      hdr_ch.valid           <= 1'b0;
      hdr_ch.header_byte     <= '0;
      hdr_ch.start_of_packet <= 1'b0;
      burst_len  = 1;
      burst_sent = 0;
      gap_left   = 0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        predict_verdict(hdr_ch.header_byte, hdr_ch.start_of_packet);
        void'(header_bytes_q.pop_front());
        burst_sent++;
      end
      // a burst only ends after a transaction, so an offered byte is never withdrawn
      if (gap_left > 0) begin
        gap_left--;
      end else if (burst_sent >= burst_len) begin
        burst_sent = 0;
        burst_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      offer = (gap_left == 0) && (header_bytes_q.size() != 0);
      hdr_ch.valid <= offer;
      if (offer) begin
        hdr_ch.header_byte     <= header_bytes_q[0].hb;
        hdr_ch.start_of_packet <= header_bytes_q[0].sop;
      end
    end
  end

  // receiver: checks every result transaction against the oldest expected verdict
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result: accepted %0d error_code %0d length %0d proto %0d",
                   $time, res_ch.accepted, res_ch.error_code, res_ch.header_length,
                   res_ch.protocol_number);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (res_ch.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0d actual %0d",
                     $time, want.accepted, res_ch.accepted);
            fail_count++;
          end
          if (res_ch.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, want.error_code, res_ch.error_code);
            fail_count++;
          end
          if (res_ch.header_length !== want.header_length) begin
            $display("%0t: header_length expected %0d actual %0d",
                     $time, want.header_length, res_ch.header_length);
            fail_count++;
          end
          if (res_ch.protocol_number !== want.protocol_number) begin
            $display("%0t: protocol_number expected %0d actual %0d",
                     $time, want.protocol_number, res_ch.protocol_number);
            fail_count++;
          end
        end
      end
      rx_cycle = rx_cycle + 1;
      // a hold-off request starts a long stall counted here
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        // stall style follows bits 8:7 of the cycle counter
        case (rx_cycle[8:7])
          2'd0: begin
            take = 1'b1;
          end
          2'd1: begin
            take = ($urandom_range(0, 1) == 0);
          end
          2'd2: begin
            take = ((rx_cycle % 7) >= 3);
          end
          default: begin
            take = ($urandom_range(0, 4) != 0);
          end
        endcase
      end
      res_ch.ready <= take;
    end
  end

  // hang detection: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst || (hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] src_val;
    logic [31:0] dst_val;
    logic [7:0]  hb;
    int          target;
    hdr_ch.valid           = 1'b0;
    hdr_ch.header_byte     = '0;
    hdr_ch.start_of_packet = 1'b0;
    res_ch.ready           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // filter settings: all wildcards, all ones, then random mixes
      case (phase)
        0: begin
          src_val = '0;
          dst_val = '0;
        end
        1: begin
          src_val = '1;
          dst_val = '1;
        end
        3: begin
          src_val = random_filter(1'b0);
          dst_val = random_filter(1'b0);
        end
        default: begin
          src_val = random_filter(1'b1);
          dst_val = random_filter(1'b1);
        end
      endcase
      write_filter(REG_SOURCE_FILTER, src_val);
      write_filter(REG_DEST_FILTER, dst_val);

      if (phase == 0) begin
        // stray byte before any start, then a zero version
        queue_beat(8'h00, 1'b0);
        queue_beat(8'h00, 1'b1);
        // ignored after the rejection
        queue_beat(8'hFF, 1'b0);
        // header abandoned by a new start
        queue_beat({IPV4_VERSION, 4'hF}, 1'b1);
        queue_beat(8'hAA, 1'b0);
        queue_beat(8'h55, 1'b0);
        // full header, largest ihl, all flags set, all-ones source, zero destination
        queue_beat({IPV4_VERSION, 4'hF}, 1'b1);
        for (int i = 1; i < HDR_BYTES; i++) begin
          if (i == POS_FRAG_HI) hb = 8'hE0;
          else if (i == POS_FRAG_LO) hb = 8'h00;
          else if (i == POS_PROTO) hb = PROTO_UDP;
          else if (i >= POS_DST) hb = 8'h00;
          else hb = 8'hFF;
          queue_beat(hb, 1'b0);
        end
      end

      if (phase == 3) begin
        // stall the receiver long while back-to-back one-byte rejects pile up
        hold_requests++;
        for (int i = 0; i < PRESSURE_PKTS; i++) begin
          queue_beat({4'($urandom_range(0, 3)), 4'($urandom)}, 1'b1);
        end
      end

      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) queue_header(pick_kind());
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ihf_pkg.sv
hdl/ihf_if.sv
hdl/ihf_cfg.sv
hdl/ihf_parse.sv
hdl/ihf_res_fifo.sv
hdl/ipv4_header_filter_top.sv
bench/tb.sv
